// File: rtl/core/boundary_tag_allocator_macros.svh
// assertion macros for the boundary tag allocator
// used by boundary_tag_allocator in rtl/core, no other dependencies
`ifndef BOUNDARY_TAG_ALLOCATOR_MACROS_SVH
`define BOUNDARY_TAG_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define BTA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BTA_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BTA_ASSERT(label, clk, rst_n, prop, msg)
`define BTA_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// File: rtl/core/bta_pkg.sv
// package for the boundary tag allocator: sizes, codes and the unit word type
// no dependencies
package bta_pkg;
  localparam int ARENA_UNITS   = 1024;
  localparam int MIN_REMAINDER = 10;
  localparam int DEPTH         = ARENA_UNITS + 2;
  localparam int AW            = $clog2(DEPTH);
  localparam int WALK_LIMIT    = ARENA_UNITS + 2;
  localparam int WCW           = $clog2(WALK_LIMIT + 1);

  localparam logic [2:0] ST_ALLOC   = 3'd0;
  localparam logic [2:0] ST_FREED   = 3'd1;
  localparam logic [2:0] ST_NOSPACE = 3'd2;
  localparam logic [2:0] ST_BADSIZE = 3'd3;
  localparam logic [2:0] ST_BADADDR = 3'd4;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_NEXT  = 2'd1;
  localparam logic [1:0] FIT_BEST  = 2'd2;

  // one unit of the arena as stored in memory
  typedef struct packed {
    logic          tag;
    logic          amap;
    logic [AW-1:0] size;
    logic [AW-1:0] prev;
    logic [AW-1:0] next;
    logic [AW-1:0] uplink;
  } unit_t;

  localparam int UW = $bits(unit_t);

  function automatic logic [AW-1:0] ix(input logic [AW:0] v);
    return (v < (AW+1)'(DEPTH)) ? v[AW-1:0] : '0;
  endfunction
endpackage

// File: rtl/core/bta_mem.sv
// unit memory for the boundary tag allocator, one port, registered read data
// a reset sweep loads the initial arena image; depends on bta_pkg
module bta_mem
  import bta_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  unit_t         wdata,
  output unit_t         rdata,
  output logic          init_done
);
  unit_t         mem [DEPTH];
  logic [AW-1:0] sweep_r;
  logic          done_r;
  unit_t         init_word;
  logic          w_en;
  logic [AW-1:0] w_addr;
  unit_t         w_data;

  always_comb begin
    init_word = '0;
    if (sweep_r == '0 || sweep_r == AW'(DEPTH - 1)) init_word.tag = 1'b1;
    if (sweep_r == AW'(1)) begin
      init_word.size = AW'(ARENA_UNITS);
      init_word.prev = AW'(1);
      init_word.next = AW'(1);
    end
    if (sweep_r == AW'(ARENA_UNITS)) init_word.uplink = AW'(1);
    w_en   = done_r ? we : 1'b1;
    w_addr = done_r ? addr : sweep_r;
    w_data = done_r ? wdata : init_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
      done_r  <= 1'b0;
    end else if (!done_r) begin
      if (sweep_r == AW'(DEPTH - 1)) done_r <= 1'b1;
      else sweep_r <= sweep_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (w_en) mem[w_addr] <= w_data;
    rdata <= mem[addr];
  end

  assign init_done = done_r;
endmodule

// File: rtl/core/boundary_tag_allocator.sv
// boundary tag allocator top level: sequencer over the unit memory
// depends on bta_pkg, bta_mem and boundary_tag_allocator_macros.svh
//
// zero size, empty list or free address out of range go straight to the result
// strobe; allocate walks the free list one node per read, and a free of an address
// that is not a block start ends after reading it; one request at a time, busy
// drops in the result strobe cycle. reset: synchronous active low; a sweep loads
// the arena image and busy stays high during it. results cannot be stalled by the
// receiver.
`include "boundary_tag_allocator_macros.svh"
module boundary_tag_allocator
  import bta_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [10:0] in_req_size,
  input  logic [10:0] in_free_addr,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [10:0] out_block_addr,
  output logic [10:0] out_block_size,
  output logic [1:0]  out_merge_kind,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_fit_strategy
);
  // sequencer states
  localparam logic [5:0] S_IDLE  = 6'd0;
  localparam logic [5:0] S_RD    = 6'd1;   // issue read of addr_r
  localparam logic [5:0] S_WAIT  = 6'd2;   // data arrives next
  localparam logic [5:0] S_DONE  = 6'd3;
  // micro steps are held in step_r; S_RD/S_WAIT return to S_EXEC
  localparam logic [5:0] S_EXEC  = 6'd4;
  localparam logic [5:0] S_WR    = 6'd5;

  // step codes
  localparam logic [4:0] P_SRCH     = 5'd0;  // read search node
  localparam logic [4:0] P_SRCH_NX  = 5'd1;
  localparam logic [4:0] P_FND      = 5'd2;  // re-read chosen p
  localparam logic [4:0] P_SPL_F    = 5'd3;  // read new footer of p
  localparam logic [4:0] P_SPL_Q    = 5'd4;  // write new footer of p
  localparam logic [4:0] P_SPL_QF   = 5'd5;  // write q header and q footer
  localparam logic [4:0] P_WH_F     = 5'd6;  // whole block: footer
  localparam logic [4:0] P_WH_A     = 5'd7;  // unlink: prev node
  localparam logic [4:0] P_WH_B     = 5'd8;  // unlink: next node
  localparam logic [4:0] P_FR_SP    = 5'd9;  // read sp
  localparam logic [4:0] P_FR_PM    = 5'd10; // read sp-1
  localparam logic [4:0] P_FR_NX    = 5'd11; // read nx
  localparam logic [4:0] P_FR_PRE   = 5'd12; // read pre
  localparam logic [4:0] P_WR_LIST  = 5'd13; // generic write queue
  localparam logic [4:0] P_FR_HEAD  = 5'd14; // read head
  localparam logic [4:0] P_FR_TAIL  = 5'd15; // read tail
  localparam logic [4:0] P_FIN      = 5'd16;

  logic [5:0]    state_r;
  logic [4:0]    step_r;
  logic [1:0]    fit_r;
  logic [AW-1:0] head_r;
  logic          empty_r;
  logic [AW-1:0] nf_r;
  logic          nfv_r;

  logic [AW-1:0] n_r;
  logic [AW-1:0] sp_r;

  // search walk
  logic [AW-1:0] p_r, start_r, bestp_r;
  logic [AW-1:0] mind_r;
  logic          have_r;
  logic [WCW-1:0] k_r;

  // held unit words
  unit_t         u_p_r;   // chosen block / sp
  unit_t         u_x_r;   // scratch
  logic [AW-1:0] pre_r, nx_r, a_r, b_r;
  logic [AW-1:0] nsz_r;   // sp size
  logic          pfree_r, nfree_r;

  // small write queue: six entries, at most 4 read-modify-writes of whole words queued
  logic [AW-1:0] wq_addr_r [6];
  logic [2:0]    wq_kind_r [6];
  logic [2:0]    wq_cnt_r, wq_i_r;

  logic [2:0]    res_st_r;
  logic [AW-1:0] res_a_r, res_s_r;
  logic [1:0]    res_m_r;
  logic          outv_r;

  // memory port
  logic          m_we;
  logic [AW-1:0] m_addr;
  unit_t         m_wd, m_rd;
  logic          init_done;
  logic [AW-1:0] addr_r;

  bta_mem u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .we        (m_we),
    .addr      (m_addr),
    .wdata     (m_wd),
    .rdata     (m_rd),
    .init_done (init_done)
  );

  // write kinds applied to a freshly read word in the queue
  localparam logic [2:0] K_SETNEXT = 3'd0;  // next <= b_r
  localparam logic [2:0] K_SETPREV = 3'd1;  // prev <= a_r
  localparam logic [2:0] K_FOOT0   = 3'd2;  // tag 0, uplink <= pre_r
  localparam logic [2:0] K_HEAD0   = 3'd3;  // tag 0, size nsz_r, prev a_r, next b_r, amap 0
  localparam logic [2:0] K_SIZE    = 3'd4;  // size <= nsz_r
  localparam logic [2:0] K_NEXTSP  = 3'd5;  // next <= sp_r
  localparam logic [2:0] K_PREVSP  = 3'd6;  // prev <= sp_r

  function automatic unit_t apply(input unit_t u, input logic [2:0] k,
                                  input logic [AW-1:0] a, input logic [AW-1:0] b,
                                  input logic [AW-1:0] pr, input logic [AW-1:0] sz,
                                  input logic [AW-1:0] s);
    unit_t r;
    r = u;
    case (k)
      K_SETNEXT: r.next = b;
      K_SETPREV: r.prev = a;
      K_FOOT0:   begin r.tag = 1'b0; r.uplink = pr; end
      K_HEAD0:   begin r.tag = 1'b0; r.size = sz; r.prev = a; r.next = b; r.amap = 1'b0; end
      K_SIZE:    r.size = sz;
      K_NEXTSP:  r.next = s;
      K_PREVSP:  r.prev = s;
      default:   r = u;
    endcase
    return r;
  endfunction

  // foot address of block at p with size s
  function automatic logic [AW-1:0] foot(input logic [AW-1:0] p, input logic [AW-1:0] s);
    return (s != '0) ? ix({1'b0, p} + {1'b0, s} - 1'b1) : p;
  endfunction

  logic wr_phase_r;  // two-phase steps: 0 issue read, 1 read data back
  logic [AW:0] diff;
  logic        acc;
  logic [AW-1:0] fq;

  // a pending request word wins over a strategy write in the same cycle
  assign busy      = (state_r != S_IDLE) || !init_done;
  assign cfg_ready = (state_r == S_IDLE) && init_done && !start;
  assign acc       = start && !busy;
  assign diff      = {1'b0, m_rd.size} - {1'b0, n_r};
  assign fq        = foot(u_p_r.uplink, u_p_r.size);

  always_comb begin
    m_we   = 1'b0;
    m_addr = addr_r;
    m_wd   = u_x_r;
    if (state_r == S_WR) m_we = 1'b1;
  end

  // enqueue helper is expressed inline; memory ops use u_x_r as write data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      step_r   <= P_FIN;
      fit_r    <= FIT_FIRST;
      head_r   <= AW'(1);
      empty_r  <= 1'b0;
      nf_r     <= '0;
      nfv_r    <= 1'b0;
      outv_r   <= 1'b0;
      wq_cnt_r <= '0;
      wq_i_r   <= '0;
      wr_phase_r <= 1'b0;
    end else begin
      outv_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            fit_r <= cfg_fit_strategy;
            nf_r  <= head_r;
            nfv_r <= !empty_r;
          end else if (acc) begin
            n_r      <= in_req_size[AW-1:0];
            sp_r     <= in_free_addr[AW-1:0];
            wq_cnt_r <= '0;
            wq_i_r   <= '0;
            res_a_r  <= '0;
            res_s_r  <= '0;
            res_m_r  <= '0;
            if (!in_req_type) begin
              if (in_req_size == '0) begin
                res_st_r <= ST_BADSIZE; state_r <= S_DONE;
              end else if (empty_r) begin
                res_st_r <= ST_NOSPACE; state_r <= S_DONE;
              end else begin
                if (fit_r == FIT_NEXT) begin
                  start_r <= nfv_r ? nf_r : head_r;
                  p_r     <= nfv_r ? nf_r : head_r;
                  addr_r  <= nfv_r ? nf_r : head_r;
                  if (!nfv_r) begin nf_r <= head_r; nfv_r <= 1'b1; end
                end else begin
                  start_r <= head_r; p_r <= head_r; addr_r <= head_r;
                end
                have_r <= 1'b0; k_r <= '0; mind_r <= '0; bestp_r <= '0;
                step_r <= P_SRCH; state_r <= S_WAIT;
              end
            end else begin
              if (in_free_addr < 11'd1 || in_free_addr > 11'(ARENA_UNITS)) begin
                res_st_r <= ST_BADADDR; state_r <= S_DONE;
              end else begin
                addr_r <= in_free_addr[AW-1:0];
                step_r <= P_FR_SP; state_r <= S_WAIT;
              end
            end
          end
        end
        S_RD: state_r <= S_WAIT;
        S_WAIT: state_r <= S_EXEC;
        S_WR: begin
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          case (step_r)
            P_SRCH: begin
              // m_rd is node p_r
              if (m_rd.size >= n_r && fit_r != FIT_BEST) begin
                p_r <= p_r; addr_r <= p_r; step_r <= P_FND; state_r <= S_WAIT;
                u_p_r <= m_rd;
              end else begin
                if (m_rd.size >= n_r && (!have_r || diff[AW-1:0] < mind_r)) begin
                  have_r <= 1'b1; mind_r <= diff[AW-1:0]; bestp_r <= p_r;
                end
                if ((m_rd.size >= n_r && diff == '0) || ix({1'b0, m_rd.next}) == start_r
                    || k_r == WCW'(WALK_LIMIT - 1)) begin
                  if ((m_rd.size >= n_r && (!have_r || diff[AW-1:0] < mind_r)) || have_r)
                  begin
                    if (m_rd.size >= n_r && (!have_r || diff[AW-1:0] < mind_r)) begin
                      p_r <= p_r; addr_r <= p_r;
                    end else begin
                      p_r <= bestp_r; addr_r <= bestp_r;
                    end
                    step_r <= P_FND; state_r <= S_WAIT;
                  end else begin
                    res_st_r <= ST_NOSPACE; state_r <= S_DONE;
                  end
                end else begin
                  p_r <= ix({1'b0, m_rd.next}); addr_r <= ix({1'b0, m_rd.next});
                  k_r <= k_r + 1'b1; state_r <= S_WAIT;
                end
              end
            end
            P_FND: begin
              // m_rd is chosen block p_r
              u_p_r <= m_rd;
              if (fit_r == FIT_NEXT) begin
                nf_r <= ix({1'b0, m_rd.next});
                if (head_r == p_r) head_r <= ix({1'b0, m_rd.next});
              end else if (fit_r == FIT_BEST) begin
                if (head_r == p_r) head_r <= ix({1'b0, m_rd.next});
              end else head_r <= ix({1'b0, m_rd.next});
              res_st_r <= ST_ALLOC;
              if (diff > (AW+1)'(MIN_REMAINDER)) begin
                // header of p: size shrinks
                u_x_r <= m_rd; u_x_r.size <= diff[AW-1:0];
                u_p_r.size <= diff[AW-1:0];
                u_p_r.uplink <= p_r;
                addr_r <= p_r; step_r <= P_SPL_F; state_r <= S_WR;
              end else begin
                u_x_r <= m_rd; u_x_r.tag <= 1'b1; u_x_r.amap <= 1'b1;
                u_p_r.uplink <= p_r;
                res_a_r <= p_r; res_s_r <= m_rd.size;
                addr_r <= p_r; step_r <= P_WH_F; state_r <= S_WR;
                a_r <= ix({1'b0, m_rd.prev}); b_r <= ix({1'b0, m_rd.next});
                if (ix({1'b0, m_rd.next}) == p_r) begin
                  empty_r <= 1'b0; // set below
                end
              end
            end
            P_SPL_F: begin
              // read footer of p for modify
              addr_r <= fq; step_r <= P_SPL_Q; state_r <= S_WAIT;
            end
            P_SPL_Q: begin
              u_x_r <= m_rd; u_x_r.tag <= 1'b0; u_x_r.uplink <= u_p_r.uplink;
              addr_r <= fq; step_r <= P_SPL_QF; state_r <= S_WR;
            end
            P_SPL_QF: begin
              if (!wr_phase_r) begin
                // q header read
                wr_phase_r <= 1'b1;
                addr_r <= ix({1'b0, fq} + 1'b1); state_r <= S_WAIT;
              end else if (wq_i_r == 3'd0) begin
                u_x_r <= m_rd; u_x_r.size <= n_r; u_x_r.tag <= 1'b1; u_x_r.amap <= 1'b1;
                res_a_r <= ix({1'b0, fq} + 1'b1); res_s_r <= n_r;
                wq_i_r <= 3'd1; state_r <= S_WR;
              end else if (wq_i_r == 3'd1) begin
                wq_i_r <= 3'd2;
                addr_r <= foot(res_a_r, n_r); state_r <= S_WAIT;
              end else begin
                u_x_r <= m_rd; u_x_r.tag <= 1'b1; u_x_r.uplink <= res_a_r;
                wr_phase_r <= 1'b0; wq_i_r <= '0;
                addr_r <= foot(res_a_r, n_r); step_r <= P_FIN; state_r <= S_WR;
              end
            end
            P_WH_F: begin
              if (!wr_phase_r) begin
                wr_phase_r <= 1'b1;
                addr_r <= foot(p_r, u_p_r.size); state_r <= S_WAIT;
              end else begin
                u_x_r <= m_rd; u_x_r.tag <= 1'b1;
                wr_phase_r <= 1'b0;
                addr_r <= foot(p_r, u_p_r.size); state_r <= S_WR;
                if (b_r == p_r) begin
                  empty_r <= 1'b1; nfv_r <= 1'b0; step_r <= P_FIN;
                end else begin
                  if (nf_r == p_r) nf_r <= b_r;
                  wq_addr_r[0] <= a_r; wq_kind_r[0] <= K_SETNEXT;
                  wq_addr_r[1] <= b_r; wq_kind_r[1] <= K_SETPREV;
                  wq_cnt_r <= 3'd2; wq_i_r <= '0;
                  step_r <= P_WR_LIST;
                end
              end
            end
            P_FR_SP: begin
              u_p_r <= m_rd; nsz_r <= m_rd.size;
              if (!m_rd.amap) begin
                res_st_r <= ST_BADADDR; state_r <= S_DONE;
              end else begin
                res_st_r <= ST_FREED;
                u_x_r <= m_rd; u_x_r.amap <= 1'b0;
                addr_r <= sp_r; state_r <= S_WR;
                if (empty_r) begin
                  u_x_r.tag <= 1'b0; u_x_r.prev <= sp_r; u_x_r.next <= sp_r;
                  head_r <= sp_r; empty_r <= 1'b0; nf_r <= sp_r; nfv_r <= 1'b1;
                  res_a_r <= sp_r; res_s_r <= m_rd.size; res_m_r <= 2'd0;
                  pre_r <= sp_r;
                  wq_addr_r[0] <= foot(sp_r, m_rd.size); wq_kind_r[0] <= K_FOOT0;
                  wq_cnt_r <= 3'd1; wq_i_r <= '0; step_r <= P_WR_LIST;
                end else step_r <= P_FR_PM;
              end
            end
            P_FR_PM: begin
              if (!wr_phase_r) begin
                wr_phase_r <= 1'b1; addr_r <= sp_r - 1'b1; state_r <= S_WAIT;
              end else begin
                wr_phase_r <= 1'b0;
                pfree_r <= !m_rd.tag; pre_r <= ix({1'b0, m_rd.uplink});
                nx_r <= ix({1'b0, sp_r} + {1'b0, nsz_r});
                addr_r <= ix({1'b0, sp_r} + {1'b0, nsz_r});
                step_r <= P_FR_NX; state_r <= S_WAIT;
              end
            end
            P_FR_NX: begin
              nfree_r <= !m_rd.tag;
              u_x_r <= m_rd;
              a_r <= ix({1'b0, m_rd.prev}); b_r <= ix({1'b0, m_rd.next});
              wq_i_r <= '0;
              if (!pfree_r && m_rd.tag) begin
                addr_r <= head_r; step_r <= P_FR_HEAD; state_r <= S_WAIT;
              end else if (pfree_r) begin
                addr_r <= pre_r; step_r <= P_FR_PRE; state_r <= S_WAIT;
              end else begin
                // merge with next only
                if (head_r == nx_r) head_r <= sp_r;
                if (nf_r == nx_r) nf_r <= sp_r;
                a_r <= (ix({1'b0, m_rd.prev}) == nx_r) ? sp_r : ix({1'b0, m_rd.prev});
                b_r <= (ix({1'b0, m_rd.next}) == nx_r) ? sp_r : ix({1'b0, m_rd.next});
                nsz_r <= nsz_r + m_rd.size;
                pre_r <= sp_r;
                res_a_r <= sp_r; res_s_r <= nsz_r + m_rd.size; res_m_r <= 2'd2;
                wq_addr_r[0] <= sp_r; wq_kind_r[0] <= K_HEAD0;
                wq_addr_r[1] <= (ix({1'b0, m_rd.prev}) == nx_r) ? sp_r
                                : ix({1'b0, m_rd.prev});
                wq_kind_r[1] <= K_NEXTSP;
                wq_addr_r[2] <= (ix({1'b0, m_rd.next}) == nx_r) ? sp_r
                                : ix({1'b0, m_rd.next});
                wq_kind_r[2] <= K_PREVSP;
                wq_addr_r[3] <= foot(sp_r, nsz_r + m_rd.size); wq_kind_r[3] <= K_FOOT0;
                wq_cnt_r <= 3'd4; step_r <= P_WR_LIST; state_r <= S_EXEC;
              end
            end
            P_FR_PRE: begin
              res_a_r <= pre_r;
              if (nfree_r) begin
                if (head_r == nx_r) head_r <= pre_r;
                if (nf_r == nx_r) nf_r <= pre_r;
                nsz_r <= m_rd.size + nsz_r + u_x_r.size;
                res_s_r <= m_rd.size + nsz_r + u_x_r.size; res_m_r <= 2'd3;
                wq_addr_r[0] <= a_r; wq_kind_r[0] <= K_SETNEXT;
                wq_addr_r[1] <= b_r; wq_kind_r[1] <= K_SETPREV;
                wq_addr_r[2] <= pre_r; wq_kind_r[2] <= K_SIZE;
                wq_addr_r[3] <= foot(pre_r, m_rd.size + nsz_r + u_x_r.size);
                wq_kind_r[3] <= K_FOOT0;
                wq_cnt_r <= 3'd4;
              end else begin
                nsz_r <= m_rd.size + nsz_r;
                res_s_r <= m_rd.size + nsz_r; res_m_r <= 2'd1;
                wq_addr_r[0] <= pre_r; wq_kind_r[0] <= K_SIZE;
                wq_addr_r[1] <= foot(pre_r, m_rd.size + nsz_r); wq_kind_r[1] <= K_FOOT0;
                wq_cnt_r <= 3'd2;
              end
              step_r <= P_WR_LIST;
            end
            P_FR_HEAD: begin
              // isolated: link sp in before head
              a_r <= ix({1'b0, m_rd.prev}); b_r <= head_r;
              pre_r <= sp_r;
              res_a_r <= sp_r; res_s_r <= nsz_r; res_m_r <= 2'd0;
              head_r <= sp_r;
              if (!nfv_r) begin nf_r <= sp_r; nfv_r <= 1'b1; end
              wq_addr_r[0] <= sp_r; wq_kind_r[0] <= K_HEAD0;
              wq_addr_r[1] <= foot(sp_r, nsz_r); wq_kind_r[1] <= K_FOOT0;
              wq_addr_r[2] <= ix({1'b0, m_rd.prev}); wq_kind_r[2] <= K_NEXTSP;
              wq_addr_r[3] <= head_r; wq_kind_r[3] <= K_PREVSP;
              wq_cnt_r <= 3'd4; step_r <= P_WR_LIST;
            end
            P_WR_LIST: begin
              if (wq_i_r == wq_cnt_r) begin
                step_r <= P_FIN;
              end else if (!wr_phase_r) begin
                wr_phase_r <= 1'b1;
                addr_r <= wq_addr_r[wq_i_r]; state_r <= S_WAIT;
              end else begin
                wr_phase_r <= 1'b0;
                u_x_r <= apply(m_rd, wq_kind_r[wq_i_r], a_r, b_r, pre_r, nsz_r, sp_r);
                wq_i_r <= wq_i_r + 1'b1; state_r <= S_WR;
              end
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_DONE: begin
          outv_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = outv_r;
  assign out_status     = res_st_r;
  assign out_block_addr = (res_st_r <= ST_FREED) ? 11'(res_a_r) : '0;
  assign out_block_size = (res_st_r <= ST_FREED) ? 11'(res_s_r) : '0;
  assign out_merge_kind = (res_st_r == ST_FREED) ? res_m_r : '0;

  `BTA_ASSERT(a_nostart_busy, clk, rst_n, out_valid |-> $past(state_r) == S_DONE, "strobe without done")
  `BTA_ASSERT(a_cfg_idle, clk, rst_n, cfg_ready |-> !outv_r || state_r == S_IDLE, "cfg while working")
  `BTA_ASSERT(a_accept_busy, clk, rst_n, acc |=> busy, "accepted item left block idle")
  `BTA_ASSERT_RST(a_rst_idle, clk, !rst_n |=> state_r == S_IDLE && !out_valid, "reset not idle")
endmodule

// File: verif/boundary_tag_allocator_tb.sv
// testbench for boundary_tag_allocator: directed and random allocate/free traffic
// checked against a behavioral allocator model; depends on bta_pkg and the rtl
`timescale 1ns / 100ps
module boundary_tag_allocator_tb;
  import bta_pkg::*;

  localparam int NU = ARENA_UNITS + 2;
  localparam longint CYCLE_LIMIT = 64'd10_000_000;

  typedef struct packed {
    logic [2:0]  status;
    logic [10:0] addr;
    logic [10:0] size;
    logic [1:0]  merge;
  } alloc_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_req_type = 1'b0;
  logic [10:0] in_req_size = '0;
  logic [10:0] in_free_addr = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [10:0] out_block_addr;
  logic [10:0] out_block_size;
  logic [1:0]  out_merge_kind;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_fit_strategy = '0;

  boundary_tag_allocator u_top (.*);

  always #6 clk = ~clk;

  // model of the arena state
  bit          m_tag [NU];
  int unsigned m_size [NU];
  int unsigned m_prev [NU];
  int unsigned m_next [NU];
  int unsigned m_up [NU];
  bit          m_amap [NU];
  int unsigned m_head;
  bit          m_empty;
  int unsigned m_nfp;
  bit          m_nfv;
  logic [1:0]  m_strat;

  alloc_word_t expected_q[$];
  int unsigned live_blocks[$];  // starts of blocks the model holds as allocated
  int          n_errors = 0;
  int          n_results = 0;
  int          n_items = 0;
  longint      cycles = 0;

  function automatic int unsigned clip(int unsigned v);
    return v < NU ? v : 0;
  endfunction

  function automatic int unsigned foot(int unsigned p);
    int unsigned s;
    s = m_size[clip(p)];
    return clip(s != 0 ? p + s - 1 : p);
  endfunction

  function automatic void tag_foot(int unsigned p, bit t);
    int unsigned f;
    f = foot(p);
    m_tag[f] = t;
    m_up[f] = clip(p);
  endfunction

  function automatic void arena_reset();
    for (int i = 0; i < NU; i++) begin
      m_tag[i] = 0; m_size[i] = 0; m_prev[i] = 0; m_next[i] = 0;
      m_up[i] = 0; m_amap[i] = 0;
    end
    m_tag[0] = 1; m_tag[NU-1] = 1;
    m_size[1] = ARENA_UNITS; m_prev[1] = 1; m_next[1] = 1;
    m_up[ARENA_UNITS] = 1;
    m_head = 1; m_empty = 0; m_nfp = 0; m_nfv = 0; m_strat = FIT_FIRST;
  endfunction

  // one lap of the free list from origin; best picks the tightest fit
  function automatic bit fit_walk(int unsigned origin, int unsigned n, bit best,
                                  output int unsigned hit);
    int unsigned p, bp, mind;
    bit got;
    p = clip(origin); bp = 0; mind = 0; got = 0;
    for (int k = 0; k < NU; k++) begin
      if (m_size[p] >= n) begin
        if (!best) begin
          hit = p;
          return 1;
        end
        if (!got || m_size[p] - n < mind) begin
          got = 1; mind = m_size[p] - n; bp = p;
          if (mind == 0) break;
        end
      end
      p = clip(m_next[p]);
      if (p == clip(origin)) break;
    end
    hit = bp;
    return got;
  endfunction

  function automatic alloc_word_t mk(logic [2:0] st, int unsigned a, int unsigned s,
                                     int unsigned m);
    alloc_word_t w;
    w.status = st; w.addr = a[10:0]; w.size = s[10:0]; w.merge = m[1:0];
    return w;
  endfunction

  function automatic alloc_word_t predict_alloc(int unsigned n);
    int unsigned p, q, a, b;
    if (n == 0) return mk(ST_BADSIZE, 0, 0, 0);
    if (m_empty) return mk(ST_NOSPACE, 0, 0, 0);
    if (m_strat == FIT_NEXT) begin
      if (!m_nfv) begin
        m_nfp = m_head; m_nfv = 1;
      end
      if (!fit_walk(m_nfp, n, 0, p)) return mk(ST_NOSPACE, 0, 0, 0);
      m_nfp = clip(m_next[p]);
      if (m_head == p) m_head = clip(m_next[p]);
    end else if (m_strat == FIT_BEST) begin
      if (!fit_walk(m_head, n, 1, p)) return mk(ST_NOSPACE, 0, 0, 0);
      if (m_head == p) m_head = clip(m_next[p]);
    end else begin
      // value 3 lands here too and acts as first fit
      if (!fit_walk(m_head, n, 0, p)) return mk(ST_NOSPACE, 0, 0, 0);
      m_head = clip(m_next[p]);
    end
    if (m_size[p] - n > MIN_REMAINDER) begin
      // split, hand out the high end
      m_size[p] -= n;
      tag_foot(p, 0);
      q = clip(foot(p) + 1);
      m_size[q] = n;
      m_tag[q] = 1;
      tag_foot(q, 1);
    end else begin
      q = p;
      m_tag[p] = 1;
      m_tag[foot(p)] = 1;
      if (clip(m_next[p]) == p) begin
        m_empty = 1; m_nfv = 0;
      end else begin
        a = clip(m_prev[p]); b = clip(m_next[p]);
        m_next[a] = b; m_prev[b] = a;
        if (m_nfp == p) m_nfp = b;
      end
    end
    m_amap[q] = 1;
    live_blocks.push_back(q);
    return mk(ST_ALLOC, q, m_size[q], 0);
  endfunction

  function automatic alloc_word_t predict_free(int unsigned sp);
    int unsigned pre, nx, h, t, a, b;
    bit pf, nf;
    if (sp < 1 || sp > ARENA_UNITS || !m_amap[sp]) return mk(ST_BADADDR, 0, 0, 0);
    m_amap[sp] = 0;
    foreach (live_blocks[i]) if (live_blocks[i] == sp) begin
      live_blocks.delete(i);
      break;
    end
    if (m_empty) begin
      m_tag[sp] = 0; tag_foot(sp, 0);
      m_prev[sp] = sp; m_next[sp] = sp;
      m_head = sp; m_empty = 0; m_nfp = sp; m_nfv = 1;
      return mk(ST_FREED, sp, m_size[sp], 0);
    end
    pf = m_tag[sp-1] == 0;
    pre = clip(m_up[sp-1]);
    nx = clip(sp + m_size[sp]);
    nf = m_tag[nx] == 0;
    if (!pf && !nf) begin
      h = clip(m_head); t = clip(m_prev[h]);
      m_tag[sp] = 0; tag_foot(sp, 0);
      m_next[sp] = h; m_prev[sp] = t;
      m_next[t] = sp; m_prev[h] = sp;
      m_head = sp;
      if (!m_nfv) begin
        m_nfp = sp; m_nfv = 1;
      end
      return mk(ST_FREED, sp, m_size[sp], 0);
    end else if (pf && !nf) begin
      m_size[pre] += m_size[sp];
      tag_foot(pre, 0);
      return mk(ST_FREED, pre, m_size[pre], 1);
    end else if (!pf) begin
      // next only: take over its list slot, a lone node becomes self-linked
      a = clip(m_prev[nx]); b = clip(m_next[nx]);
      if (a == nx) a = sp;
      if (b == nx) b = sp;
      if (m_head == nx) m_head = sp;
      if (m_nfp == nx) m_nfp = sp;
      m_prev[sp] = a; m_next[sp] = b;
      m_next[a] = sp; m_prev[b] = sp;
      m_size[sp] += m_size[nx];
      m_tag[sp] = 0; tag_foot(sp, 0);
      return mk(ST_FREED, sp, m_size[sp], 2);
    end
    // both sides: unlink next wherever it sits
    a = clip(m_prev[nx]); b = clip(m_next[nx]);
    if (m_head == nx) m_head = pre;
    if (m_nfp == nx) m_nfp = pre;
    m_next[a] = b; m_prev[b] = a;
    m_size[pre] += m_size[sp] + m_size[nx];
    tag_foot(pre, 0);
    return mk(ST_FREED, pre, m_size[pre], 3);
  endfunction

  // sender: one request word, handshake on start and not busy
  // start stays high after the accepting edge until the next word or a gap
  task automatic send_req(bit typ, int unsigned sz, int unsigned fa);
    alloc_word_t w;
    // random gap before a word, none inside a burst
    if ($urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= typ;
    in_req_size <= sz[10:0];
    in_free_addr <= fa[10:0];
    do @(posedge clk); while (busy);
    // accepted at this edge
    w = typ ? predict_free(fa & 11'h7FF) : predict_alloc(sz & 11'h7FF);
    expected_q.push_back(w);
    n_items++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    // no-result items do not exist here, still let the sequencer settle
    repeat (8) @(posedge clk);
  endtask

  task automatic set_strategy(logic [1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_fit_strategy <= v;
    do @(posedge clk); while (!cfg_ready);
    m_strat = v;
    m_nfp = m_head;
    m_nfv = !m_empty;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int unsigned pick_live();
    if (live_blocks.size() == 0) return $urandom_range(0, 2047);
    return live_blocks[$urandom_range(0, live_blocks.size() - 1)];
  endfunction

  // result checker: results cannot be held off, so every strobe is taken
  always @(posedge clk) begin
    alloc_word_t e;
    if (rst_n && out_valid) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: status %0d", out_status);
        n_errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_status); n_errors++;
        end
        if (out_block_addr !== e.addr) begin
          $error("block_addr expected %0d actual %0d", e.addr, out_block_addr);
          n_errors++;
        end
        if (out_block_size !== e.size) begin
          $error("block_size expected %0d actual %0d", e.size, out_block_size);
          n_errors++;
        end
        if (out_merge_kind !== e.merge) begin
          $error("merge_kind expected %0d actual %0d", e.merge, out_merge_kind);
          n_errors++;
        end
      end
    end
  end

  // watchdog; allows for the reset sweep and long fit walks
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // field extremes, bad sizes and addresses, oversize
  task automatic test_edges();
    send_req(0, 0, 0);
    send_req(0, 1025, 0);
    send_req(0, 2047, 0);
    send_req(1, 0, 0);
    send_req(1, 0, 1025);
    send_req(1, 0, 2047);
    send_req(1, 0, 500);
    send_req(0, 1, 0);
    send_req(0, 5, 0);
  endtask

  // isolated, previous-only and both-sides coalesce cases plus emptying the list
  task automatic test_merges();
    int unsigned a, b, c;
    send_req(0, 100, 0); a = live_blocks[$];
    send_req(0, 100, 0); b = live_blocks[$];
    send_req(0, 100, 0); c = live_blocks[$];
    send_req(1, 0, b);          // isolated
    send_req(1, 0, c);          // both neighbours
    send_req(1, 0, a);          // previous neighbour only
    while (live_blocks.size() != 0) send_req(1, 0, live_blocks[0]);
    // take the whole arena, list runs empty
    send_req(0, 1024, 0);
    send_req(0, 1, 0);
    send_req(1, 0, live_blocks[0]);
    send_req(0, 1015, 0);       // remainder below the minimum, whole block
    send_req(1, 0, live_blocks[0]);
  endtask

  task automatic test_random(int count);
    int unsigned r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        if ($urandom_range(0, 9) == 0) send_req(0, $urandom_range(0, 2047), $urandom());
        else send_req(0, $urandom_range(1, 64), $urandom_range(0, 2047));
      end else if (r < 92) begin
        send_req(1, $urandom_range(0, 2047), pick_live());
      end else begin
        send_req(1, $urandom_range(0, 2047), $urandom_range(0, 2047));
      end
      if (i % 150 == 75) drain();   // let everything land mid-stream
    end
  endtask

  initial begin
    arena_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_edges();
    test_merges();
    set_strategy(FIT_NEXT);
    test_random(280);
    set_strategy(FIT_BEST);
    test_random(280);
    set_strategy(2'd3);
    test_random(260);
    set_strategy(FIT_FIRST);
    test_random(260);
    drain();
    repeat (40) @(posedge clk);
    $display("covered %0d requests, %0d result words, all fit strategies", n_items,
             n_results);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
